/* rtl/gbsp_pkg.sv */
// ----------------------------------------------------------------------------
// gbsp_pkg: shared types and constants for the grid path router
// Datapath command codes, status bundle, neighbor order and result limits.
// ----------------------------------------------------------------------------
`default_nettype none

package gbsp_pkg;

  localparam int MAX_RESULTS = 64;

  // neighbor scan order
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WALL_CLR,
    OP_WALL_WR,
    OP_LATCH,
    OP_INFO_CLR,
    OP_SEED,
    OP_POP_RD,
    OP_POP_LD,
    OP_NB_RD,
    OP_NB_EV,
    OP_GOAL_RD,
    OP_GOAL_LD,
    OP_TB_INIT,
    OP_TN_RD,
    OP_TN_EV,
    OP_OUT_HIT,
    OP_OUT_MISS,
    OP_OUT_PATH,
    OP_ADV
  } gbsp_op_t;

  typedef struct packed {
    logic clr_done;
    logic q_empty;
    logic k_last;
    logic same_cell;
    logic off_grid;
    logic goal_seen;
    logic d_zero;
    logic out_last;
  } gbsp_stat_t;

endpackage

`default_nettype wire

/* rtl/gbsp_dpath.sv */
// ----------------------------------------------------------------------------
// gbsp_dpath: map, cell info and wave queue memories with search registers
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module gbsp_dpath import gbsp_pkg::*; #(
  parameter int GRID_ROWS = 8,
  parameter int GRID_COLS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  gbsp_op_t        op,
  input  wire logic [2:0] row,
  input  wire logic [2:0] col,
  input  wire logic       blocked,
  input  wire logic [2:0] goal_row,
  input  wire logic [2:0] goal_col,
  output gbsp_stat_t      stat,
  output logic [2:0]      path_row,
  output logic [2:0]      path_col,
  output logic [5:0]      distance,
  output logic            found,
  output logic            last
);

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW = $clog2(NCELLS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int IW = 1 + 2 * AW;   // {seen, dist, rank}
  localparam int QW = AW + RW + CW; // {dist, row, col}

  logic          wall_mem [NCELLS];
  logic [IW-1:0] info_mem [NCELLS];
  logic [QW-1:0] q_mem    [NCELLS];

  logic          wall_q;
  logic [IW-1:0] info_q;
  logic [QW-1:0] q_q;

  logic [AW-1:0] clr_cnt;
  logic [2:0]    s_row, s_col, g_row, g_col;
  logic [RW-1:0] cur_row, nxt_row, nb_row;
  logic [CW-1:0] cur_col, nxt_col, nb_col;
  logic [AW-1:0] cur_d;
  logic [AW:0]   head, tail;
  logic [1:0]    k;
  logic          have;
  logic [AW-1:0] best;
  logic [5:0]    n;
  logic          goal_seen;

  logic          nb_in;
  logic [AW-1:0] nb_addr, g_addr, s_addr, wr_addr, info_ra;
  logic          wr_in_grid;
  logic          i_seen;
  logic [AW-1:0] i_dist, i_rank;
  logic          disc, tcand, fin;

  assign i_seen = info_q[IW-1];
  assign i_dist = info_q[2*AW-1:AW];
  assign i_rank = info_q[AW-1:0];

  always_comb begin
    nb_row = cur_row;
    nb_col = cur_col;
    nb_in  = 1'b0;
    case (k)
      DIR_LEFT: begin
        nb_in  = (cur_col != '0);
        nb_col = cur_col - CW'(1);
      end
      DIR_RIGHT: begin
        nb_in  = (32'(cur_col) != GRID_COLS - 1);
        nb_col = cur_col + CW'(1);
      end
      DIR_UP: begin
        nb_in  = (cur_row != '0);
        nb_row = cur_row - RW'(1);
      end
      DIR_DOWN: begin
        nb_in  = (32'(cur_row) != GRID_ROWS - 1);
        nb_row = cur_row + RW'(1);
      end
      default: nb_in = 1'b0;
    endcase
  end

  assign nb_addr    = AW'(32'(nb_row) * GRID_COLS + 32'(nb_col));
  assign g_addr     = AW'(32'(g_row) * GRID_COLS + 32'(g_col));
  assign s_addr     = AW'(32'(s_row) * GRID_COLS + 32'(s_col));
  assign wr_addr    = AW'(32'(row) * GRID_COLS + 32'(col));
  assign wr_in_grid = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
  assign info_ra    = (op == OP_GOAL_RD) ? g_addr : nb_addr;

  assign disc  = nb_in && !wall_q && !i_seen && (tail < (AW+1)'(NCELLS));
  assign tcand = nb_in && i_seen && (({1'b0, i_dist} + (AW+1)'(1)) == {1'b0, cur_d})
                 && (!have || (i_rank < best));
  assign fin   = (cur_d == '0) || !have || (n == 6'(MAX_RESULTS - 1));

  // memories
  always_ff @(posedge clk) begin
    case (op)
      OP_WALL_CLR: wall_mem[clr_cnt] <= 1'b0;
      OP_WALL_WR:  if (wr_in_grid) wall_mem[wr_addr] <= blocked;
      default: ;
    endcase
    wall_q <= wall_mem[nb_addr];

    case (op)
      OP_INFO_CLR: info_mem[clr_cnt] <= '0;
      OP_SEED:     info_mem[s_addr] <= {1'b1, {AW{1'b0}}, {AW{1'b0}}};
      OP_NB_EV:    if (disc) info_mem[nb_addr] <= {1'b1, cur_d + AW'(1), tail[AW-1:0]};
      default: ;
    endcase
    info_q <= info_mem[info_ra];

    case (op)
      OP_SEED:  q_mem[0] <= {{AW{1'b0}}, RW'(s_row), CW'(s_col)};
      OP_NB_EV: if (disc) q_mem[tail[AW-1:0]] <= {cur_d + AW'(1), nb_row, nb_col};
      default: ;
    endcase
    q_q <= q_mem[head[AW-1:0]];
  end

  // search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else begin
      case (op)
        OP_WALL_CLR, OP_INFO_CLR: begin
          clr_cnt <= stat.clr_done ? '0 : clr_cnt + AW'(1);
        end
        OP_LATCH: begin
          s_row <= row;
          s_col <= col;
          g_row <= goal_row;
          g_col <= goal_col;
        end
        OP_SEED: begin
          head <= '0;
          tail <= (AW+1)'(1);
        end
        OP_POP_LD: begin
          {cur_d, cur_row, cur_col} <= q_q;
          head <= head + (AW+1)'(1);
          k    <= DIR_LEFT;
        end
        OP_NB_EV: begin
          if (disc) tail <= tail + (AW+1)'(1);
          k <= k + 2'd1;
        end
        OP_GOAL_LD: begin
          cur_row   <= RW'(g_row);
          cur_col   <= CW'(g_col);
          cur_d     <= i_dist;
          goal_seen <= i_seen;
          n         <= '0;
        end
        OP_TB_INIT: begin
          have <= 1'b0;
          k    <= DIR_LEFT;
        end
        OP_TN_EV: begin
          if (tcand) begin
            have    <= 1'b1;
            best    <= i_rank;
            nxt_row <= nb_row;
            nxt_col <= nb_col;
          end
          k <= k + 2'd1;
        end
        OP_OUT_HIT, OP_OUT_MISS: begin
          path_row <= g_row;
          path_col <= g_col;
          distance <= '0;
          found    <= (op == OP_OUT_HIT);
          last     <= 1'b1;
        end
        OP_OUT_PATH: begin
          path_row <= 3'(cur_row);
          path_col <= 3'(cur_col);
          distance <= 6'(cur_d);
          found    <= 1'b1;
          last     <= fin;
        end
        OP_ADV: begin
          cur_row <= nxt_row;
          cur_col <= nxt_col;
          cur_d   <= cur_d - AW'(1);
          n       <= n + 6'd1;
        end
        default: ;
      endcase
    end
  end

  assign stat.clr_done  = (32'(clr_cnt) == NCELLS - 1);
  assign stat.q_empty   = (head == tail);
  assign stat.k_last    = (k == DIR_DOWN);
  assign stat.same_cell = (s_row == g_row) && (s_col == g_col);
  assign stat.off_grid  = (32'(s_row) >= GRID_ROWS) || (32'(s_col) >= GRID_COLS) ||
                          (32'(g_row) >= GRID_ROWS) || (32'(g_col) >= GRID_COLS);
  assign stat.goal_seen = goal_seen;
  assign stat.d_zero    = (cur_d == '0);
  assign stat.out_last  = last;

endmodule

`default_nettype wire

/* rtl/gbsp_ctrl.sv */
// ----------------------------------------------------------------------------
// gbsp_ctrl: sequencing state machine for the grid path router
// Issues one datapath command per cycle and runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module gbsp_ctrl import gbsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic  action,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  gbsp_stat_t stat,
  output gbsp_op_t   op
);

  typedef enum logic [4:0] {
    S_RST_CLR,
    S_IDLE,
    S_CHK,
    S_CLR,
    S_SEED,
    S_POP,
    S_POPW,
    S_NB,
    S_NBW,
    S_GOAL,
    S_GOALW,
    S_GCHK,
    S_TB,
    S_TN,
    S_TNW,
    S_EMIT,
    S_OUT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_RST_CLR: begin
        op = OP_WALL_CLR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_WRITE) begin
            op = OP_WALL_WR;
          end else begin
            op         = OP_LATCH;
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (stat.same_cell) begin
          op         = OP_OUT_HIT;
          state_next = S_OUT;
        end else if (stat.off_grid) begin
          op         = OP_OUT_MISS;
          state_next = S_OUT;
        end else begin
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        op = OP_INFO_CLR;
        if (stat.clr_done) state_next = S_SEED;
      end
      S_SEED: begin
        op         = OP_SEED;
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.q_empty) begin
          state_next = S_GOAL;
        end else begin
          op         = OP_POP_RD;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        op         = OP_POP_LD;
        state_next = S_NB;
      end
      S_NB: begin
        op         = OP_NB_RD;
        state_next = S_NBW;
      end
      S_NBW: begin
        op         = OP_NB_EV;
        state_next = stat.k_last ? S_POP : S_NB;
      end
      S_GOAL: begin
        op         = OP_GOAL_RD;
        state_next = S_GOALW;
      end
      S_GOALW: begin
        op         = OP_GOAL_LD;
        state_next = S_GCHK;
      end
      S_GCHK: begin
        if (stat.goal_seen) begin
          state_next = S_TB;
        end else begin
          op         = OP_OUT_MISS;
          state_next = S_OUT;
        end
      end
      S_TB: begin
        if (stat.d_zero) begin
          op         = OP_OUT_PATH;
          state_next = S_OUT;
        end else begin
          op         = OP_TB_INIT;
          state_next = S_TN;
        end
      end
      S_TN: begin
        op         = OP_TN_RD;
        state_next = S_TNW;
      end
      S_TNW: begin
        op = OP_TN_EV;
        // the chosen step settles on the last neighbor; the word loads next
        state_next = stat.k_last ? S_EMIT : S_TN;
      end
      S_EMIT: begin
        op         = OP_OUT_PATH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (stat.out_last) begin
            state_next = S_IDLE;
          end else begin
            op         = OP_ADV;
            state_next = S_TB;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RST_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

`default_nettype wire

/* rtl/grid_bfs_shortest_path.sv */
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path: grid maze router with breadth-first wave and
// trace-back. Writes set map cells; searches stream the path goal first.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid, in_stall, action, row, col, blocked, | in
//          | goal_row, goal_col                             |
//  out     | out_valid, out_stall, path_row, path_col,      | out
//          | distance, found, last                          |
//
//  Map write: taken in idle, in_stall stays low. Search: clears the cell
//  info memory, runs the wave (queue pop, then a read and an evaluate per
//  neighbor of each reached cell), then the trace-back (a scan of the
//  neighbors of each path cell before its word; none for the start cell),
//  plus output stalls. Start equal to goal, or an off-grid cell, gives its
//  word from the check state after accept. Reset sweeps the wall map open
//  with in_stall high. A stalled output holds the walk; one search at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_shortest_path import gbsp_pkg::*; #(
  parameter int GRID_ROWS = 8,
  parameter int GRID_COLS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       action,
  input  wire logic [2:0] row,
  input  wire logic [2:0] col,
  input  wire logic       blocked,
  input  wire logic [2:0] goal_row,
  input  wire logic [2:0] goal_col,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      path_row,
  output logic [2:0]      path_col,
  output logic [5:0]      distance,
  output logic            found,
  output logic            last
);

  gbsp_op_t   op;
  gbsp_stat_t stat;

  gbsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .op        (op)
  );

  gbsp_dpath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .row      (row),
    .col      (col),
    .blocked  (blocked),
    .goal_row (goal_row),
    .goal_col (goal_col),
    .stat     (stat),
    .path_row (path_row),
    .path_col (path_col),
    .distance (distance),
    .found    (found),
    .last     (last)
  );

endmodule

`default_nettype wire
